// ===== sv/dgs_pkg.sv =====
// Shared types, constants and table helpers for the digit group separator iterator.
// Used by dgs_ctrl, dgs_dp and digit_group_separator_iterator_top.
package dgs_pkg;

  localparam int GROUP_ENTRIES = 4;    // grouping entries honored per table
  localparam int TABLE_DEPTH   = 4;    // entries stored per table
  localparam int MAX_DIGITS    = 255;  // digit count cap
  localparam int GROUP_STOP    = 127;  // entry value that ends grouping
  localparam int DIG_W         = 8;    // digit counters and separator count
  localparam int NR_W          = 10;   // non-repeating digit total
  localparam int GIDX_W        = 3;    // group index
  localparam int CFG_IDX_W     = 3;    // configuration register index
  localparam int DIV_STEPS     = DIG_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  typedef logic signed [7:0] entry_t;
  // [table][entry][bit]; table 0 numeric, table 1 monetary
  typedef logic [1:0][TABLE_DEPTH-1:0][7:0] tbl_t;

  localparam tbl_t TBL_RESET = {8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd3};

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WALK,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;     // load counters for a new number
    logic step;      // advance one digit and load the output word
    logic walk;      // walk one grouping table entry
    logic div_step;  // one restoring division step
    logic div_last;  // final division step, fold quotient and remainder back
    logic emit;      // load the start result into the output word
  } dgs_cmd_t;

  typedef struct packed {
    logic trivial;   // the pending start item needs no table walk
    logic walk_end;  // the walk finishes in this entry
    logic walk_div;  // the walk reached a repeating entry, divide next
    logic out_free;  // the output register can take a word this cycle
  } dgs_status_t;

  // Entries past the configured table read as zero, i.e. repeat.
  function automatic entry_t entry_at(tbl_t t, logic sel, logic [GIDX_W-1:0] idx);
    entry_t v;
    v = '0;
    if (int'(idx) < GROUP_ENTRIES && int'(idx) < TABLE_DEPTH) begin
      v = entry_t'(t[sel][idx[1:0]]);
    end
    return v;
  endfunction

  function automatic logic ends_grouping(entry_t v);
    return (v == entry_t'(GROUP_STOP)) || v[7];
  endfunction

endpackage

// ===== sv/dgs_ctrl.sv =====
// Controller state machine of the digit group separator iterator.
// Depends on dgs_pkg; drives dgs_dp through dgs_cmd_t and reads dgs_status_t.
module dgs_ctrl
  import dgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_mode,
  output logic        in_ready,
  input  dgs_status_t status,
  output dgs_cmd_t    cmd
);

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   cnt_last;

  assign cnt_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt_nxt = (state_r == S_DIV) ? cnt_r + DIV_CNT_W'(1) : '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            state_nxt = status.out_free ? S_IDLE : S_STEP;
          end else begin
            state_nxt = status.trivial ? S_EMIT : S_WALK;
          end
        end
      end
      S_STEP: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      S_WALK: begin
        if (status.walk_end) begin
          state_nxt = S_EMIT;
        end else if (status.walk_div) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step  = in_mode && status.out_free;
          cmd.start = !in_mode;
        end
      end
      S_STEP: cmd.step = status.out_free;
      S_WALK: cmd.walk = 1'b1;
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = cnt_last;
      end
      S_EMIT: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== sv/dgs_dp.sv =====
// Datapath of the digit group separator iterator: grouping tables, digit counters,
// bit-serial divider for repeating groups and the output register. Depends on dgs_pkg.
module dgs_dp
  import dgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [DIG_W-1:0]     in_digit_count,
  input  logic                 in_use_monetary,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_separator_before,
  output logic                 out_grouping_active,
  output logic [DIG_W-1:0]     out_separator_count,
  output logic                 out_underrun_error,
  input  dgs_cmd_t             cmd,
  output dgs_status_t          status
);

  tbl_t               tbl_r, tbl_nxt;
  logic [DIG_W-1:0]   dl_r, dl_nxt;       // digits left
  logic [DIG_W-1:0]   dlig_r, dlig_nxt;   // digits left in group, remainder during setup
  logic [GIDX_W-1:0]  gi_r, gi_nxt;
  logic [NR_W-1:0]    nr_r, nr_nxt;
  logic [DIG_W-1:0]   sep_r, sep_nxt;
  logic               sel_r, sel_nxt;
  logic [DIG_W-1:0]   dvd_r, dvd_nxt;     // dividend shifting out, quotient shifting in
  logic [DIG_W-1:0]   part_r, part_nxt;   // partial remainder
  logic [DIG_W-1:0]   size_r, size_nxt;   // divisor
  logic               out_valid_r, out_valid_nxt;
  logic               osb_r, osb_nxt;
  logic               oact_r, oact_nxt;
  logic [DIG_W-1:0]   ocnt_r, ocnt_nxt;
  logic               oun_r, oun_nxt;

  logic [DIG_W-1:0]   d_cap;
  entry_t             first;
  entry_t             w_size_s, w_next;
  logic [DIG_W-1:0]   w_size;
  logic               w_le;
  logic [DIG_W-1:0]   p_sh, p_nx, q_nx;
  logic               p_ge;
  logic               underrun;
  logic [DIG_W-1:0]   dl_dec;
  logic [GIDX_W-1:0]  gi_dec;
  entry_t             step_v;
  logic               out_free;

  // Start item: clamp the count and look at the first entry of the chosen table.
  assign d_cap = (int'(in_digit_count) > MAX_DIGITS) ? DIG_W'(MAX_DIGITS) : in_digit_count;
  assign first = entry_at(tbl_r, in_use_monetary, '0);

  // Table walk: current entry and the one after it.
  assign w_size_s = entry_at(tbl_r, sel_r, gi_r);
  assign w_next   = entry_at(tbl_r, sel_r, gi_r + GIDX_W'(1));
  assign w_size   = DIG_W'($unsigned(w_size_s));
  assign w_le     = (dlig_r <= w_size);

  // Restoring division, one quotient bit per cycle.
  assign p_sh = {part_r[DIG_W-2:0], dvd_r[DIG_W-1]};
  assign p_ge = (p_sh >= size_r);
  assign p_nx = p_ge ? p_sh - size_r : p_sh;
  assign q_nx = {dvd_r[DIG_W-2:0], p_ge};

  // Digit step.
  assign underrun = (dl_r == '0);
  assign dl_dec   = dl_r - DIG_W'(1);
  assign gi_dec   = (({{(NR_W-DIG_W){1'b0}}, dl_dec} < nr_r) && (gi_r != '0))
                    ? gi_r - GIDX_W'(1) : gi_r;
  assign step_v   = entry_at(tbl_r, sel_r, gi_dec);

  assign out_free = !out_valid_r || out_ready;

  assign status.trivial  = (d_cap <= DIG_W'(1)) || (first <= 8'sd0)
                           || (first == entry_t'(GROUP_STOP));
  assign status.walk_end = w_le || ends_grouping(w_next);
  assign status.walk_div = !w_le && (w_next == 8'sd0);
  assign status.out_free = out_free;

  always_comb begin
    tbl_nxt       = tbl_r;
    dl_nxt        = dl_r;
    dlig_nxt      = dlig_r;
    gi_nxt        = gi_r;
    nr_nxt        = nr_r;
    sep_nxt       = sep_r;
    sel_nxt       = sel_r;
    dvd_nxt       = dvd_r;
    part_nxt      = part_r;
    size_nxt      = size_r;
    osb_nxt       = osb_r;
    oact_nxt      = oact_r;
    ocnt_nxt      = ocnt_r;
    oun_nxt       = oun_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_we) begin
      tbl_nxt[cfg_index[2]][cfg_index[1:0]] = cfg_data;
    end

    priority if (cmd.start) begin
      // The same load serves the no-grouping case and the start of a walk.
      sel_nxt  = in_use_monetary;
      dl_nxt   = d_cap;
      dlig_nxt = d_cap;
      gi_nxt   = '0;
      nr_nxt   = '0;
      sep_nxt  = '0;
    end else if (cmd.walk) begin
      if (w_le) begin
        nr_nxt = nr_r + NR_W'(w_size);
      end else begin
        dlig_nxt = dlig_r - w_size;
        sep_nxt  = sep_r + DIG_W'(1);
        if (w_next == 8'sd0) begin
          // Repeating group: the rest is handled by dividing by this size.
          dvd_nxt  = dlig_r - w_size - DIG_W'(1);
          part_nxt = '0;
          size_nxt = w_size;
        end else begin
          nr_nxt = nr_r + NR_W'(w_size);
          gi_nxt = gi_r + GIDX_W'(1);
        end
      end
    end else if (cmd.div_step) begin
      dvd_nxt  = q_nx;
      part_nxt = p_nx;
      if (cmd.div_last) begin
        sep_nxt  = sep_r + q_nx;
        dlig_nxt = p_nx + DIG_W'(1);
      end
    end else if (cmd.step) begin
      out_valid_nxt = 1'b1;
      osb_nxt       = 1'b0;
      oact_nxt      = 1'b0;
      ocnt_nxt      = '0;
      oun_nxt       = underrun;
      if (!underrun) begin
        dl_nxt = dl_dec;
        if (dlig_r != '0) begin
          dlig_nxt = dlig_r - DIG_W'(1);
        end else begin
          gi_nxt   = gi_dec;
          dlig_nxt = (step_v > 8'sd1) ? DIG_W'($unsigned(step_v)) - DIG_W'(1) : '0;
          osb_nxt  = 1'b1;
        end
      end
    end else if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      osb_nxt       = 1'b0;
      oun_nxt       = 1'b0;
      oact_nxt      = (sep_r != '0);
      ocnt_nxt      = sep_r;
    end else begin
      dl_nxt = dl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r       <= TBL_RESET;
      dl_r        <= '0;
      dlig_r      <= '0;
      gi_r        <= '0;
      nr_r        <= '0;
      sep_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tbl_r       <= tbl_nxt;
      dl_r        <= dl_nxt;
      dlig_r      <= dlig_nxt;
      gi_r        <= gi_nxt;
      nr_r        <= nr_nxt;
      sep_r       <= sep_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    part_r <= part_nxt;
    size_r <= size_nxt;
    osb_r  <= osb_nxt;
    oact_r <= oact_nxt;
    ocnt_r <= ocnt_nxt;
    oun_r  <= oun_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_separator_before = osb_r;
  assign out_grouping_active  = oact_r;
  assign out_separator_count  = ocnt_r;
  assign out_underrun_error   = oun_r;

endmodule

// ===== sv/digit_group_separator_iterator_top.sv =====
// Top level of the digit group separator iterator.
// Depends on dgs_pkg, dgs_ctrl and dgs_dp.
//
// Usage: the input channel (in_valid/in_ready) takes one word per item. A word with
// in_mode 0 starts a number: in_digit_count digits, table chosen by in_use_monetary.
// Its result word gives out_separator_count and out_grouping_active. Each following
// word with in_mode 1 walks one digit, most significant first, and its result word
// says whether a separator precedes that digit, or flags an underrun when no digits
// are left. Exactly one result word comes back per input word, in order.
// Digit words: the result is loaded into the output register once the word is taken
// and the register is free; a new digit word is accepted every cycle while the
// output register drains. A start word walks one grouping entry at a time (up to
// four) and, when a repeating entry is reached, runs the bit-serial divider, then
// loads the result. No input is accepted during that time. The cfg port writes the
// eight grouping entries (0..3 numeric, 4..7 monetary); the user must do so only
// while idle; the block does not enforce it. Reset (rst_n low, synchronous) restores
// the tables to 3,0,0,0, clears the digit counters and empties the output register.
// When out_ready is low, the result word holds in the output register; a digit word
// arriving then is taken and waits in the controller until the register frees up.
module digit_group_separator_iterator_top
  import dgs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [DIG_W-1:0]     in_digit_count,
  input  logic                 in_use_monetary,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_separator_before,
  output logic                 out_grouping_active,
  output logic [DIG_W-1:0]     out_separator_count,
  output logic                 out_underrun_error
);

  dgs_cmd_t    cmd;
  dgs_status_t status;

  dgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dgs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_digit_count       (in_digit_count),
    .in_use_monetary      (in_use_monetary),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_separator_before (out_separator_before),
    .out_grouping_active  (out_grouping_active),
    .out_separator_count  (out_separator_count),
    .out_underrun_error   (out_underrun_error),
    .cmd                  (cmd),
    .status               (status)
  );

  // The controller issues at most one datapath operation per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.start, cmd.step, cmd.walk, cmd.div_step, cmd.emit}))
    else $error("more than one datapath command in a cycle");

  // The last division step only comes with a division step.
  a_div_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> cmd.div_step)
    else $error("division finish without a division step");

  // No input is taken while a table walk or division is running.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk || cmd.div_step) |-> !in_ready)
    else $error("input ready during setup");

  // A start result reports grouping exactly when it counts separators.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid && (out_grouping_active == (out_separator_count != '0)))
    else $error("start result inconsistent");

endmodule

// ===== sim/tb_digit_group_separator_iterator_top.sv =====
// Self-checking testbench for digit_group_separator_iterator_top.
// Needs dgs_pkg and the block's RTL; a built-in grouping predictor checks every result word.
`timescale 1ns / 100ps

module tb_digit_group_separator_iterator_top;
  import dgs_pkg::*;

  localparam int IDLE_MAX         = 13;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS     = 700;
  localparam int SETTLE_CYCLES    = 20;
  localparam int REPORT_LIMIT     = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM0, REG_NUM1, REG_NUM2, REG_NUM3,
    REG_MON0, REG_MON1, REG_MON2, REG_MON3
  } cfg_reg_e;

  typedef enum logic {MODE_START, MODE_NEXT} word_mode_e;
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic             sep_before;
    logic             active;
    logic [DIG_W-1:0] sep_count;
    logic             underrun;
  } grp_word_t;

  typedef struct packed {
    row_kind_e        kind;
    word_mode_e       mode;
    logic [DIG_W-1:0] count;
    logic             monetary;
    cfg_reg_e         reg_idx;
    logic [7:0]       reg_val;
    logic             typed;      // expected word given in the row
    logic [DIG_W-1:0] sep_count;
    logic             underrun;
  } dir_row_t;

  localparam int DIR_ROWS = 37;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Fresh after reset: an empty number, then a digit with nothing left.
    '{ROW_WORD, MODE_START, 8'd0,   1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b1 ^ 1'b1},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b1},
    '{ROW_WORD, MODE_START, 8'd1,   1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b1},
    '{ROW_WORD, MODE_START, 8'd255, 1'b0, REG_NUM0, 8'd0,   1'b1, 8'd84,  1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd255, 1'b1, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd7,   1'b1, REG_NUM0, 8'd0,   1'b1, 8'd2,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    // A first entry that stops, is negative or is zero disables grouping.
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM0, 8'd127, 1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd10,  1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM0, 8'h80,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd10,  1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd200, 1'b0, REG_NUM0, 8'd0,   1'b1, 8'd0,   1'b0},
    // 3 then 2 repeated: 12,34,56,789.
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM0, 8'd3,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM1, 8'd2,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd9,   1'b0, REG_NUM0, 8'd0,   1'b1, 8'd3,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    // All-ones table, where the entry past the end repeats, then a stop in entry 1.
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_MON0, 8'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_MON1, 8'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_MON2, 8'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_MON3, 8'd1,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd255, 1'b1, REG_NUM0, 8'd0,   1'b1, 8'd254, 1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_MON1, 8'd127, 1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd255, 1'b1, REG_NUM0, 8'd0,   1'b1, 8'd1,   1'b0},
    // Rewrite the first entry negative while a number is half walked.
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM1, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_START, 8'd5,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  MODE_START, 8'd0,   1'b0, REG_NUM0, 8'hFB,  1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0},
    '{ROW_WORD, MODE_NEXT,  8'd0,   1'b0, REG_NUM0, 8'd0,   1'b0, 8'd0,   1'b0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [DIG_W-1:0]     in_digit_count;
  logic                 in_use_monetary;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_separator_before;
  logic                 out_grouping_active;
  logic [DIG_W-1:0]     out_separator_count;
  logic                 out_underrun_error;

  digit_group_separator_iterator_top uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_digit_count       (in_digit_count),
    .in_use_monetary      (in_use_monetary),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_separator_before (out_separator_before),
    .out_grouping_active  (out_grouping_active),
    .out_separator_count  (out_separator_count),
    .out_underrun_error   (out_underrun_error)
  );

  // Predictor copy of the grouping tables and the digit walk counters.
  logic signed [7:0] grp_tbl [2][TABLE_DEPTH];
  int unsigned       left_digits;
  int unsigned       left_in_group;
  int unsigned       grp_idx;
  int unsigned       nonrep_total;
  int unsigned       sep_total;
  logic              tbl_sel;

  grp_word_t words_due [$];
  grp_word_t due_word;
  grp_word_t got_word;
  int        miscompares;
  bit        tx_steady;
  bit        rx_steady;
  bit        rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb_digit_group_separator_iterator_top NOT OK");
    $finish;
  end

  function automatic int entry_of(logic sel, int unsigned idx);
    if (idx >= GROUP_ENTRIES || idx >= TABLE_DEPTH) return 0;
    return grp_tbl[sel][idx];
  endfunction

  function automatic grp_word_t next_grouping_word(logic mode, logic [DIG_W-1:0] count,
                                                   logic monetary);
    grp_word_t   w;
    int unsigned d, rem, nr, groups, g, reps;
    int          lead, grp_size, nxt, v;
    bit          done;
    w = '0;
    if (mode == MODE_START) begin
      d = (count > MAX_DIGITS) ? MAX_DIGITS : count;
      tbl_sel = monetary;
      lead = entry_of(tbl_sel, 0);
      left_digits = d;
      if (d <= 1 || lead == GROUP_STOP || lead <= 0) begin
        left_in_group = d;
        grp_idx = 0;
        nonrep_total = 0;
        sep_total = 0;
      end else begin
        rem = d;
        nr = 0;
        groups = 0;
        g = 0;
        done = 1'b0;
        while (!done) begin
          grp_size = entry_of(tbl_sel, g);
          nr += grp_size;
          if (rem <= grp_size) begin
            done = 1'b1;
          end else begin
            groups++;
            rem -= grp_size;
            g++;
            nxt = entry_of(tbl_sel, g);
            if (nxt == GROUP_STOP || nxt < 0) begin
              done = 1'b1;
            end else if (nxt == 0) begin
              // A zero entry repeats the last size over all remaining digits.
              g--;
              nr -= grp_size;
              reps = (rem - 1) / grp_size;
              groups += reps;
              rem -= reps * grp_size;
              done = 1'b1;
            end
          end
        end
        left_in_group = rem & 32'hFF;
        grp_idx = g & 32'h7;
        nonrep_total = nr & 32'h3FF;
        sep_total = groups & 32'hFF;
      end
      w.sep_count = sep_total[DIG_W-1:0];
      w.active = (sep_total != 0);
    end else if (left_digits == 0) begin
      w.underrun = 1'b1;
    end else begin
      left_digits--;
      if (left_in_group > 0) begin
        left_in_group--;
      end else begin
        if (left_digits < nonrep_total && grp_idx > 0) grp_idx--;
        v = entry_of(tbl_sel, grp_idx);
        left_in_group = (v > 1) ? v - 1 : 0;
        w.sep_before = 1'b1;
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] pick_entry(bit lead);
    logic [7:0] v;
    if (lead && $urandom_range(0, 3) != 0) begin
      v = 8'($urandom_range(1, 4));
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = 8'($urandom_range(1, 4));
        4:          v = 8'd0;
        5:          v = 8'd127;
        6:          v = 8'h80;
        7:          v = 8'($urandom_range(128, 255));
        8:          v = 8'd126;
        default:    v = 8'($urandom);
      endcase
    end
    return v;
  endfunction

  // Offer one word; the expected result is queued once the block takes it.
  task automatic send_word(logic mode, logic [DIG_W-1:0] count, logic monetary,
                           bit typed, grp_word_t typed_word);
    int        gap;
    grp_word_t w;
    gap = tx_steady ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_digit_count  <= count;
    in_use_monetary <= monetary;
    do @(posedge clk); while (!in_ready);
    w = next_grouping_word(mode, count, monetary);
    words_due.push_back(typed ? typed_word : w);
  endtask

  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [7:0] val);
    drain_words();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    grp_tbl[idx[2]][idx[1:0]] = val;
  endtask

  // Result side: random back-pressure, with one long hold on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        gap = LONG_HOLD_CYCLES;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, IDLE_MAX);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_separator_before, out_grouping_active, out_separator_count,
                   out_underrun_error};
      if (words_due.size() == 0) begin
        miscompares++;
        if (miscompares <= REPORT_LIMIT)
          $display("%0t: unexpected word sep=%b act=%b cnt=%0d und=%b", $realtime,
                   got_word.sep_before, got_word.active, got_word.sep_count,
                   got_word.underrun);
      end else begin
        due_word = words_due.pop_front();
        if (got_word.sep_before !== due_word.sep_before || got_word.active !== due_word.active
            || got_word.sep_count !== due_word.sep_count
            || got_word.underrun !== due_word.underrun) begin
          miscompares++;
          if (miscompares <= REPORT_LIMIT)
            $display("%0t: expected sep=%b act=%b cnt=%0d und=%b, got sep=%b act=%b cnt=%0d und=%b",
                     $realtime, due_word.sep_before, due_word.active, due_word.sep_count,
                     due_word.underrun, got_word.sep_before, got_word.active,
                     got_word.sep_count, got_word.underrun);
        end
      end
    end
  end

  initial begin
    int               i, r, items, walk, nums;
    logic [DIG_W-1:0] cnt;
    bit               hold_done;
    grp_word_t        typed_word;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_mode         = 1'b0;
    in_digit_count  = '0;
    in_use_monetary = 1'b0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    rx_hold_req     = 1'b0;
    miscompares     = 0;
    hold_done       = 1'b0;
    for (i = 0; i < 2 * TABLE_DEPTH; i++) grp_tbl[i / TABLE_DEPTH][i % TABLE_DEPTH] = '0;
    grp_tbl[0][0] = 8'sd3;
    grp_tbl[1][0] = 8'sd3;
    left_digits   = 0;
    left_in_group = 0;
    grp_idx       = 0;
    nonrep_total  = 0;
    sep_total     = 0;
    tbl_sel       = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        typed_word = '{1'b0, dir_rows[i].sep_count != 0, dir_rows[i].sep_count,
                       dir_rows[i].underrun};
        send_word(dir_rows[i].mode, dir_rows[i].count, dir_rows[i].monetary,
                  dir_rows[i].typed, typed_word);
      end
    end

    items = 0;
    while (items < RANDOM_ITEMS) begin
      for (r = 0; r < 2 * TABLE_DEPTH; r++)
        cfg_write(cfg_reg_e'(r), pick_entry(r % TABLE_DEPTH == 0));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      // Digits left over from a number cut short before the rewrite.
      walk = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
      repeat (walk) send_word(MODE_NEXT, DIG_W'($urandom), 1'($urandom), 1'b0, '0);
      items += walk;
      nums = $urandom_range(2, 6);
      repeat (nums) begin
        if ($urandom_range(0, 7) == 0) cnt = DIG_W'($urandom_range(0, 255));
        else cnt = DIG_W'($urandom_range(0, 16));
        if (!hold_done) begin
          // Stall the result side while words keep coming back to back.
          hold_done   = 1'b1;
          tx_steady   = 1'b1;
          rx_hold_req = 1'b1;
          cnt         = DIG_W'(40);
        end
        send_word(MODE_START, cnt, 1'($urandom), 1'b0, '0);
        walk = cnt + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) walk = $urandom_range(0, walk);
        repeat (walk) send_word(MODE_NEXT, DIG_W'($urandom), 1'($urandom), 1'b0, '0);
        items += 1 + walk;
      end
    end

    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (miscompares == 0 && words_due.size() == 0) begin
      $display("tb_digit_group_separator_iterator_top OK");
    end else begin
      $display("tb_digit_group_separator_iterator_top NOT OK");
    end
    $finish;
  end

endmodule
